// File: src/pal_sls_pkg.sv
// shared types and constants for the pal sync line sequencer
package pal_sls_pkg;

  // field widths
  localparam int unsigned TICKS_W = 10;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned LINE_W  = 9;

  // configuration port geometry
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned REG_IDX_W = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LINE_PERIOD     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LINE_SYNC_WIDTH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EQUALIZE_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_VSYNC_WIDTH     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;

  // register reset values
  localparam logic [TICKS_W-1:0] RST_LINE_PERIOD     = 10'd32;
  localparam logic [TICKS_W-1:0] RST_LINE_SYNC_WIDTH = 10'd2;
  localparam logic [TICKS_W-1:0] RST_HALF_PERIOD     = 10'd16;
  localparam logic [TICKS_W-1:0] RST_EQUALIZE_WIDTH  = 10'd1;
  localparam logic [TICKS_W-1:0] RST_VSYNC_WIDTH     = 10'd15;
  localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT    = 8'd64;

  // frame structure
  localparam int unsigned NORMAL_LINES_DEF = 305;
  localparam logic [LINE_W-1:0] FIELD2_HALFLINES = 9'd14;
  localparam logic [LINE_W-1:0] FIELD1_HALFLINES = 9'd16;
  localparam logic [LINE_W-1:0] FIELD2_BROAD_FIRST = 9'd5;
  localparam logic [LINE_W-1:0] FIELD1_BROAD_FIRST = 9'd6;
  localparam logic [LINE_W-1:0] BROAD_COUNT = 9'd5;
  localparam logic signed [LINE_W:0] ROW_OFFSET = 10'sd29;

  // line kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_SYNC   = 1'b1;

  // configuration register set
  typedef struct packed {
    logic [TICKS_W-1:0] line_period;
    logic [TICKS_W-1:0] line_sync_width;
    logic [TICKS_W-1:0] half_period;
    logic [TICKS_W-1:0] equalize_width;
    logic [TICKS_W-1:0] vsync_width;
    logic [ROW_W-1:0]   image_height;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [TICKS_W-1:0] period_ticks;
    logic [TICKS_W-1:0] sync_width;
    logic               line_kind;
    logic [ROW_W-1:0]   image_row;
    logic               row_visible;
    logic [PHASE_W-1:0] field_phase;
    logic [LINE_W-1:0]  line_index;
  } res_t;

endpackage

// File: src/pal_sls_if.sv
// valid/ready channel interfaces for the input and result items
interface pal_sls_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface pal_sls_out_if;
  logic                                valid;
  logic                                ready;
  logic [pal_sls_pkg::TICKS_W-1:0]     period_ticks;
  logic [pal_sls_pkg::TICKS_W-1:0]     sync_width;
  logic                                line_kind;
  logic [pal_sls_pkg::ROW_W-1:0]       image_row;
  logic                                row_visible;
  logic [pal_sls_pkg::PHASE_W-1:0]     field_phase;
  logic [pal_sls_pkg::LINE_W-1:0]      line_index;

  modport source (output valid, input ready, output period_ticks, output sync_width,
                  output line_kind, output image_row, output row_visible,
                  output field_phase, output line_index);
  modport sink (input valid, output ready, input period_ticks, input sync_width,
                input line_kind, input image_row, input row_visible,
                input field_phase, input line_index);
endinterface

// File: src/pal_sync_line_sequencer.sv
// PAL sync line sequencer top level. Each input transfer is one timer period
// end (tick = 1 advances, tick = 0 only reports) and yields exactly one result
// transfer: the length, sync width, kind and image row of the period that
// follows. The frame runs NORMAL_LINES normal lines, 14 field-2 sync half-lines,
// NORMAL_LINES normal lines and 16 field-1 sync half-lines. One item is taken
// per clock while the skid entry is free; the result register, or the skid
// entry first under stall, holds each result. A two-entry output stage keeps
// input transfers going while a result waits. Timing registers sit on the APB
// port at 4*index and should be written only while the block is idle.
module pal_sync_line_sequencer #(
  parameter int unsigned NORMAL_LINES = pal_sls_pkg::NORMAL_LINES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pal_sls_in_if.sink                      in_ch,
  pal_sls_out_if.source                   out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pal_sls_pkg::ADDR_W-1:0]  paddr,
  input  logic [pal_sls_pkg::DATA_W-1:0]  pwdata,
  output logic [pal_sls_pkg::DATA_W-1:0]  prdata,
  output logic                            pready
);

  pal_sls_pkg::cfg_t cfg;
  pal_sls_pkg::res_t res;
  logic              push_ready;
  logic              accept;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  pal_sls_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pal_sls_seq #(
    .NORMAL_LINES (NORMAL_LINES)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (accept),
    .tick   (in_ch.tick),
    .res    (res)
  );

  pal_sls_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (push_ready),
    .push_data  (res),
    .out_ch     (out_ch)
  );

endmodule

// File: src/pal_sls_cfg.sv
// apb register file holding the timing configuration
module pal_sls_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pal_sls_pkg::ADDR_W-1:0]  paddr,
  input  logic [pal_sls_pkg::DATA_W-1:0]  pwdata,
  output logic [pal_sls_pkg::DATA_W-1:0]  prdata,
  output logic                            pready,
  output pal_sls_pkg::cfg_t               cfg
);

  pal_sls_pkg::cfg_t                  cfg_r;
  logic [pal_sls_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pal_sls_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_period     <= pal_sls_pkg::RST_LINE_PERIOD;
      cfg_r.line_sync_width <= pal_sls_pkg::RST_LINE_SYNC_WIDTH;
      cfg_r.half_period     <= pal_sls_pkg::RST_HALF_PERIOD;
      cfg_r.equalize_width  <= pal_sls_pkg::RST_EQUALIZE_WIDTH;
      cfg_r.vsync_width     <= pal_sls_pkg::RST_VSYNC_WIDTH;
      cfg_r.image_height    <= pal_sls_pkg::RST_IMAGE_HEIGHT;
    end else if (wr_en) begin
      case (reg_idx)
        pal_sls_pkg::REG_LINE_PERIOD:
          cfg_r.line_period <= pwdata[pal_sls_pkg::TICKS_W-1:0];
        pal_sls_pkg::REG_LINE_SYNC_WIDTH:
          cfg_r.line_sync_width <= pwdata[pal_sls_pkg::TICKS_W-1:0];
        pal_sls_pkg::REG_HALF_PERIOD:
          cfg_r.half_period <= pwdata[pal_sls_pkg::TICKS_W-1:0];
        pal_sls_pkg::REG_EQUALIZE_WIDTH:
          cfg_r.equalize_width <= pwdata[pal_sls_pkg::TICKS_W-1:0];
        pal_sls_pkg::REG_VSYNC_WIDTH:
          cfg_r.vsync_width <= pwdata[pal_sls_pkg::TICKS_W-1:0];
        pal_sls_pkg::REG_IMAGE_HEIGHT:
          cfg_r.image_height <= pwdata[pal_sls_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      pal_sls_pkg::REG_LINE_PERIOD:
        prdata = {{(pal_sls_pkg::DATA_W-pal_sls_pkg::TICKS_W){1'b0}}, cfg_r.line_period};
      pal_sls_pkg::REG_LINE_SYNC_WIDTH:
        prdata = {{(pal_sls_pkg::DATA_W-pal_sls_pkg::TICKS_W){1'b0}}, cfg_r.line_sync_width};
      pal_sls_pkg::REG_HALF_PERIOD:
        prdata = {{(pal_sls_pkg::DATA_W-pal_sls_pkg::TICKS_W){1'b0}}, cfg_r.half_period};
      pal_sls_pkg::REG_EQUALIZE_WIDTH:
        prdata = {{(pal_sls_pkg::DATA_W-pal_sls_pkg::TICKS_W){1'b0}}, cfg_r.equalize_width};
      pal_sls_pkg::REG_VSYNC_WIDTH:
        prdata = {{(pal_sls_pkg::DATA_W-pal_sls_pkg::TICKS_W){1'b0}}, cfg_r.vsync_width};
      pal_sls_pkg::REG_IMAGE_HEIGHT:
        prdata = {{(pal_sls_pkg::DATA_W-pal_sls_pkg::ROW_W){1'b0}}, cfg_r.image_height};
      default: prdata = '0;
    endcase
  end

endmodule

// File: src/pal_sls_seq.sv
// phase and line counter with the per-line timing decode
module pal_sls_seq #(
  parameter int unsigned NORMAL_LINES = pal_sls_pkg::NORMAL_LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pal_sls_pkg::cfg_t  cfg,
  input  logic               accept,
  input  logic               tick,
  output pal_sls_pkg::res_t  res
);

  localparam logic [pal_sls_pkg::LINE_W-1:0] NORMAL_LEN = NORMAL_LINES[pal_sls_pkg::LINE_W-1:0];

  logic [pal_sls_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [pal_sls_pkg::LINE_W-1:0]  line_r, line_nxt;

  logic [pal_sls_pkg::LINE_W-1:0]  phase_len;
  logic [pal_sls_pkg::LINE_W:0]    line_inc;
  logic [pal_sls_pkg::LINE_W-1:0]  broad_first;
  logic                            in_broad;
  logic signed [pal_sls_pkg::LINE_W:0] row_diff;
  logic signed [pal_sls_pkg::LINE_W:0] row_quot;
  logic [pal_sls_pkg::ROW_W-1:0]   row;

  // image row: (line - 29) / 2 truncated toward zero
  assign row_diff = $signed({1'b0, line_r}) - pal_sls_pkg::ROW_OFFSET;
  assign row_quot = (row_diff + $signed({{pal_sls_pkg::LINE_W{1'b0}}, row_diff[pal_sls_pkg::LINE_W]}))
                    >>> 1;
  assign row      = row_quot[pal_sls_pkg::ROW_W-1:0];

  // broad pulse window within a sync phase
  assign broad_first = phase_r[1] ? pal_sls_pkg::FIELD1_BROAD_FIRST
                                  : pal_sls_pkg::FIELD2_BROAD_FIRST;
  assign in_broad = (line_r >= broad_first) && (line_r < broad_first + pal_sls_pkg::BROAD_COUNT);

  // result decode
  always_comb begin
    res.field_phase = phase_r;
    res.line_index  = line_r;
    if (!phase_r[0]) begin
      res.period_ticks = cfg.line_period;
      res.sync_width   = cfg.line_sync_width;
      res.line_kind    = pal_sls_pkg::KIND_NORMAL;
      res.image_row    = row;
      res.row_visible  = row < cfg.image_height;
    end else begin
      res.period_ticks = cfg.half_period;
      res.sync_width   = in_broad ? cfg.vsync_width : cfg.equalize_width;
      res.line_kind    = pal_sls_pkg::KIND_SYNC;
      res.image_row    = '0;
      res.row_visible  = 1'b0;
    end
  end

  // advance position on a tick
  assign phase_len = !phase_r[0] ? NORMAL_LEN
                   : (phase_r[1] ? pal_sls_pkg::FIELD1_HALFLINES
                                 : pal_sls_pkg::FIELD2_HALFLINES);
  assign line_inc  = {1'b0, line_r} + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    if (accept && tick) begin
      if (line_inc >= {1'b0, phase_len}) begin
        line_nxt  = '0;
        phase_nxt = phase_r + 1'b1;
      end else begin
        line_nxt  = line_inc[pal_sls_pkg::LINE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      line_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// File: src/pal_sls_obuf.sv
// result register with a skid entry so one more input transfer is taken under stall
module pal_sls_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  pal_sls_pkg::res_t  push_data,
  pal_sls_out_if.source      out_ch
);

  pal_sls_pkg::res_t main_r, skid_r;
  logic              main_v_r, skid_v_r;
  logic              push;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ch.ready) begin
      main_v_r <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!main_v_r || out_ch.ready) begin
      main_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign out_ch.valid        = main_v_r;
  assign out_ch.period_ticks = main_r.period_ticks;
  assign out_ch.sync_width   = main_r.sync_width;
  assign out_ch.line_kind    = main_r.line_kind;
  assign out_ch.image_row    = main_r.image_row;
  assign out_ch.row_visible  = main_r.row_visible;
  assign out_ch.field_phase  = main_r.field_phase;
  assign out_ch.line_index   = main_r.line_index;

endmodule
